// ===== rtl/core/rgb_to_argb_weighted_alpha_unit_defines.svh =====
// Assertion macros shared by the RGB to ARGB weighted alpha unit.
// Assumes the including module has clk and rst_n in scope.
`ifndef RGB_TO_ARGB_WEIGHTED_ALPHA_UNIT_DEFINES_SVH
`define RGB_TO_ARGB_WEIGHTED_ALPHA_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ARGBWA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ARGBWA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/argbwa_pkg.sv =====
// Shared types and constants for the RGB to ARGB weighted alpha unit.
// No dependencies.
package argbwa_pkg;

    localparam logic [31:0] CTRL_RESET  = 32'hFF00_0000;
    localparam logic [31:0] WEIGHT_MASK = 32'h00FF_FFFF;

    localparam int CH_W    = 8;   // one color channel
    localparam int PROD_W  = 16;  // weight * channel
    localparam int SUM_W   = 18;  // sum of three products
    localparam int WSUM_W  = 10;  // sum of three weights
    localparam int QUO_W   = 8;   // alpha quotient
    localparam int REM_W   = 18;  // (scale * sum) >> 8
    localparam int SCL_W   = SUM_W + CH_W;

    localparam int DIV_STEPS_DEFAULT = 2;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pix_t;

    typedef struct packed {
        pix_t             pix;
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
    } div_item_t;

endpackage

// ===== rtl/core/argbwa_mac.sv =====
// Weighted-sum front end: channel products, their sum, and the alpha scale.
// Three register stages with valid/ready. Depends on argbwa_pkg.
module argbwa_mac
    import argbwa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] ctrl,
    input  logic        in_valid,
    output logic        in_ready,
    input  pix_t        in_pix,
    output logic        out_valid,
    input  logic        out_ready,
    output div_item_t   out_item
);

    logic              a_valid_reg;
    logic              b_valid_reg;
    logic              c_valid_reg;
    logic              a_ready;
    logic              b_ready;
    logic              c_ready;

    pix_t              a_pix_reg;
    logic [PROD_W-1:0] a_pr_reg;
    logic [PROD_W-1:0] a_pg_reg;
    logic [PROD_W-1:0] a_pb_reg;
    logic [PROD_W-1:0] a_pr_next;
    logic [PROD_W-1:0] a_pg_next;
    logic [PROD_W-1:0] a_pb_next;

    pix_t              b_pix_reg;
    logic [SUM_W-1:0]  b_sum_reg;
    logic [SUM_W-1:0]  b_sum_next;

    div_item_t         c_item_reg;
    div_item_t         c_item_next;
    logic [SCL_W-1:0]  scaled;

    assign c_ready  = !c_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    assign a_pr_next = PROD_W'(in_pix.red)   * PROD_W'(ctrl[23:16]);
    assign a_pg_next = PROD_W'(in_pix.green) * PROD_W'(ctrl[15:8]);
    assign a_pb_next = PROD_W'(in_pix.blue)  * PROD_W'(ctrl[7:0]);

    assign b_sum_next = SUM_W'(a_pr_reg) + SUM_W'(a_pg_reg) + SUM_W'(a_pb_reg);

    // dividing by 256 up front keeps the divider narrow; floors compose
    assign scaled = SCL_W'(b_sum_reg) * SCL_W'(ctrl[31:24]);

    always_comb
    begin
        c_item_next     = '0;
        c_item_next.pix = b_pix_reg;
        c_item_next.rem = scaled[SCL_W-1:CH_W];
        c_item_next.quo = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= in_valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
            if (c_ready)
                c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && a_ready)
        begin
            a_pix_reg <= in_pix;
            a_pr_reg  <= a_pr_next;
            a_pg_reg  <= a_pg_next;
            a_pb_reg  <= a_pb_next;
        end
        if (a_valid_reg && b_ready)
        begin
            b_pix_reg <= a_pix_reg;
            b_sum_reg <= b_sum_next;
        end
        if (b_valid_reg && c_ready)
            c_item_reg <= c_item_next;
    end

    assign out_valid = c_valid_reg;
    assign out_item  = c_item_reg;

endmodule

// ===== rtl/core/argbwa_div_stage.sv =====
// One stage of the restoring divider: resolves STEPS quotient bits,
// starting at FIRST_BIT and going down. Depends on argbwa_pkg.
module argbwa_div_stage
    import argbwa_pkg::*;
#(
    parameter int STEPS     = DIV_STEPS_DEFAULT,
    parameter int FIRST_BIT = QUO_W - 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [WSUM_W-1:0] wsum,
    input  logic              in_valid,
    output logic              in_ready,
    input  div_item_t         in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output div_item_t         out_item
);

    logic      valid_reg;
    div_item_t item_reg;
    div_item_t item_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        logic [REM_W-1:0] rem_v;
        logic [QUO_W-1:0] quo_v;
        logic [REM_W-1:0] trial;
        rem_v = in_item.rem;
        quo_v = in_item.quo;
        trial = '0;
        for (int s = 0; s < STEPS; s++)
        begin
            trial = REM_W'(wsum) << (FIRST_BIT - s);
            if (rem_v >= trial)
            begin
                rem_v = rem_v - trial;
                quo_v = quo_v | (QUO_W'(1) << (FIRST_BIT - s));
            end
        end
        item_next     = in_item;
        item_next.rem = rem_v;
        item_next.quo = quo_v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== rtl/core/rgb_to_argb_weighted_alpha_unit.sv =====
// Top level of the RGB to ARGB weighted alpha unit.
// Depends on argbwa_pkg, argbwa_mac, argbwa_div_stage and the defines header.
`include "rgb_to_argb_weighted_alpha_unit_defines.svh"

// Takes one RGB pixel per item and returns one ARGB8888 word per item, in
// order. Throughput is one item per clock while out_ready is high. The
// weighted sum and scaling run in the MAC front end, then the restoring
// divider stages, each resolving DIV_STEPS quotient bits, divide
// by the weight sum. Each stage stalls only when the one after it is full,
// so bubbles are squeezed out and input keeps flowing while a result waits.
// alpha_control is written through cfg_valid/cfg_data (always ready); write
// it only while no item is in flight. Low 24 bits zero give constant alpha
// from bits 31-24; otherwise alpha = scale*(wr*R+wg*G+wb*B)/((wr+wg+wb)*256).
module rgb_to_argb_weighted_alpha_unit
    import argbwa_pkg::*;
#(
    parameter int DIV_STEPS = DIV_STEPS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] argb_word
);

    localparam int NUM_DIV = QUO_W / DIV_STEPS;

    logic [31:0]       ctrl_reg;
    logic [WSUM_W-1:0] wsum;
    logic              const_mode;
    pix_t              in_pix;
    logic [7:0]        alpha;

    logic              q_valid [NUM_DIV+1];
    logic              q_ready [NUM_DIV+1];
    div_item_t         q_item  [NUM_DIV+1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctrl_reg <= CTRL_RESET;
        else if (cfg_valid && cfg_ready)
            ctrl_reg <= cfg_data;
    end

    assign const_mode = (ctrl_reg & WEIGHT_MASK) == 32'h0;
    assign wsum = WSUM_W'(ctrl_reg[23:16]) + WSUM_W'(ctrl_reg[15:8])
                + WSUM_W'(ctrl_reg[7:0]);

    assign in_pix.red   = red;
    assign in_pix.green = green;
    assign in_pix.blue  = blue;

    argbwa_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_pix    (in_pix),
        .out_valid (q_valid[0]),
        .out_ready (q_ready[0]),
        .out_item  (q_item[0])
    );

    for (genvar i = 0; i < NUM_DIV; i++)
    begin : g_div
        argbwa_div_stage #(
            .STEPS     (DIV_STEPS),
            .FIRST_BIT (QUO_W - 1 - i * DIV_STEPS)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .wsum      (wsum),
            .in_valid  (q_valid[i]),
            .in_ready  (q_ready[i]),
            .in_item   (q_item[i]),
            .out_valid (q_valid[i+1]),
            .out_ready (q_ready[i+1]),
            .out_item  (q_item[i+1])
        );
    end

    // constant mode bypasses the quotient; wsum is zero there
    assign alpha = const_mode ? ctrl_reg[31:24] : q_item[NUM_DIV].quo;

    assign out_valid        = q_valid[NUM_DIV];
    assign q_ready[NUM_DIV] = out_ready;
    assign argb_word        = {alpha, q_item[NUM_DIV].pix.red,
                               q_item[NUM_DIV].pix.green, q_item[NUM_DIV].pix.blue};

    `ARGBWA_ASSERT_IMPL(a_rem_below_divisor, out_valid && !const_mode,
        q_item[NUM_DIV].rem < REM_W'(wsum), "divider remainder not below weight sum")
    `ARGBWA_ASSERT_IMPL(a_alpha_below_max, out_valid && !const_mode,
        argb_word[31:24] != 8'hFF, "weighted alpha reached 255")
    `ARGBWA_ASSERT_IMPL(a_zero_scale, out_valid && !const_mode && ctrl_reg[31:24] == 8'h00,
        argb_word[31:24] == 8'h00, "zero scale gave nonzero alpha")
    `ARGBWA_ASSERT_NEXT(a_divider_entry, q_valid[0] && q_ready[0] && q_item[0].quo == '0,
        q_valid[1], "item entering divider was lost")

endmodule
